@@ rtl/nfcfb_pkg.sv @@
// shared types, constants and the bit-reversal function of the frame builder
// no dependencies
package nfcfb_pkg;

   localparam logic [7:0] TFI_HOST      = 8'hD4;
   localparam logic [7:0] START_CODE_HI = 8'hFF;
   localparam logic [7:0] PAD_BYTE      = 8'h00;
   localparam logic [7:0] CMD_RESET     = 8'h01;

   // byte positions of one request's burst, in order of emission
   typedef enum logic [3:0] {
      SLOT_CMD,
      SLOT_PRE0,
      SLOT_PRE1,
      SLOT_START,
      SLOT_LEN,
      SLOT_LCS,
      SLOT_TFI,
      SLOT_DATA,
      SLOT_DCS,
      SLOT_POST
   } slot_type;

   // what one request emits
   typedef struct packed {
      logic       header;
      logic       data_en;
      logic       trailer;
      logic [7:0] cmd;
      logic [7:0] flen;
      logic [7:0] data;
      logic [7:0] dcs;
   } burst_type;

   function automatic logic [7:0] bit_rev(input logic [7:0] v);
      logic [7:0] x;
      x = ((v >> 1) & 8'h55) | ((v << 1) & 8'hAA);
      x = ((x >> 2) & 8'h33) | ((x << 2) & 8'hCC);
      x = ((x >> 4) & 8'h0F) | ((x << 4) & 8'hF0);
      return x;
   endfunction

endpackage

@@ rtl/nfcfb_framer.sv @@
// frame tracking: byte count, length and checksum of the open frame
// depends on nfcfb_pkg; builds the burst descriptor for each accepted request
module nfcfb_framer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic [7:0]           frame_length,
   input  logic [7:0]           write_command,
   output nfcfb_pkg::burst_type burst
);
   import nfcfb_pkg::*;

   logic [7:0] bytes_done_ff, bytes_done_in;
   logic [7:0] held_length_ff, held_length_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] bytes_inc;

   assign bytes_inc = bytes_done_ff + 8'd1;

   always_comb begin
      bytes_done_in  = bytes_done_ff;
      held_length_in = held_length_ff;
      running_sum_in = running_sum_ff;
      burst.header   = 1'b0;
      burst.data_en  = 1'b1;
      burst.trailer  = 1'b0;
      burst.cmd      = write_command;
      burst.flen     = frame_length + 8'd1;
      burst.data     = data_byte;
      if (bytes_done_ff == 8'd0) begin
         burst.header = 1'b1;
         if (frame_length == 8'd0) begin
            // empty frame: header and trailer only
            running_sum_in = TFI_HOST;
            burst.data_en  = 1'b0;
            burst.trailer  = 1'b1;
         end else begin
            held_length_in = frame_length;
            running_sum_in = TFI_HOST + data_byte;
            burst.trailer  = (frame_length == 8'd1);
            bytes_done_in  = burst.trailer ? 8'd0 : 8'd1;
         end
      end else begin
         running_sum_in = running_sum_ff + data_byte;
         burst.trailer  = (bytes_inc == held_length_ff);
         bytes_done_in  = burst.trailer ? 8'd0 : bytes_inc;
      end
      burst.dcs = 8'd0 - running_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_done_ff  <= 8'd0;
         held_length_ff <= 8'd0;
         running_sum_ff <= 8'd0;
      end else if (accept) begin
         bytes_done_ff  <= bytes_done_in;
         held_length_ff <= held_length_in;
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

@@ rtl/nfcfb_emitter.sv @@
// burst register, slot sequencer and output register of the frame builder
// depends on nfcfb_pkg; takes burst descriptors from nfcfb_framer
module nfcfb_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  nfcfb_pkg::burst_type burst_next,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_frame_end
);
   import nfcfb_pkg::*;

   burst_type  burst_ff;
   logic       busy_ff, busy_in;
   slot_type   slot_ff, slot_in, slot_step;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] tx_byte_ff;
   logic       run_last_ff;
   logic       frame_end_ff;
   logic       out_free;
   logic       advance;
   logic       is_last;
   logic [7:0] raw_byte;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = busy_ff && out_free;
   assign is_last    = (slot_ff == (burst_ff.trailer ? SLOT_POST : SLOT_DATA));
   assign load_ready = !busy_ff || (advance && is_last);

   always_comb begin
      unique case (slot_ff)
         SLOT_CMD:   slot_step = SLOT_PRE0;
         SLOT_PRE0:  slot_step = SLOT_PRE1;
         SLOT_PRE1:  slot_step = SLOT_START;
         SLOT_START: slot_step = SLOT_LEN;
         SLOT_LEN:   slot_step = SLOT_LCS;
         SLOT_LCS:   slot_step = SLOT_TFI;
         SLOT_TFI:   slot_step = burst_ff.data_en ? SLOT_DATA : SLOT_DCS;
         SLOT_DATA:  slot_step = SLOT_DCS;
         SLOT_DCS:   slot_step = SLOT_POST;
         default:    slot_step = SLOT_POST;
      endcase
   end

   always_comb begin
      unique case (slot_ff)
         SLOT_CMD:   raw_byte = burst_ff.cmd;
         SLOT_PRE0:  raw_byte = PAD_BYTE;
         SLOT_PRE1:  raw_byte = PAD_BYTE;
         SLOT_START: raw_byte = START_CODE_HI;
         SLOT_LEN:   raw_byte = burst_ff.flen;
         SLOT_LCS:   raw_byte = 8'd0 - burst_ff.flen;
         SLOT_TFI:   raw_byte = TFI_HOST;
         SLOT_DATA:  raw_byte = burst_ff.data;
         SLOT_DCS:   raw_byte = burst_ff.dcs;
         default:    raw_byte = PAD_BYTE;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (load) begin
         busy_in = 1'b1;
         slot_in = burst_next.header ? SLOT_CMD : SLOT_DATA;
      end else if (advance) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            slot_in = slot_step;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= SLOT_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst_next;
      end
      if (advance) begin
         tx_byte_ff   <= bit_rev(raw_byte);
         run_last_ff  <= is_last;
         frame_end_ff <= (slot_ff == SLOT_POST);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

@@ rtl/nfc_frame_builder_lsb_first.sv @@
// Builds normal information frames for an NFC controller from payload requests and
// emits them as bit-reversed bytes for a least-significant-bit-first serial link.
// The first request of a frame carries the payload length and yields the write
// command, 00 00 FF, LEN, LCS, TFI D4 and its data byte; each later request yields
// its data byte; the last one adds DCS and a 00 postamble. A zero length yields the
// whole empty frame from one request. Each request yields between one and ten
// result bytes, one result byte per cycle unless rsp_stall is high; a request whose
// burst is one byte can then be taken every cycle, while header and trailer bursts
// hold off the next request until their last byte enters the output register. The
// burst and output registers let a new request enter while a result still waits.
// write_command resets to 01; users must write it only between frames, unchecked.
// depends on nfcfb_pkg, nfcfb_framer and nfcfb_emitter
module nfc_frame_builder_lsb_first (
   input  logic       clock,
   input  logic       reset,
   // payload requests
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_frame_length,
   // serial byte results
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end,
   // command register write
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import nfcfb_pkg::*;

   logic [7:0] write_command_ff;
   logic       accept;
   logic       load_ready;
   burst_type  burst;

   // command byte register, sent unreversed into the burst
   always_ff @(posedge clock) begin
      if (reset) begin
         write_command_ff <= CMD_RESET;
      end else if (csr_write_enable) begin
         write_command_ff <= csr_write_data;
      end
   end

   // a request enters when the burst register is free or empties this cycle
   assign req_stall = !load_ready;
   assign accept    = req_valid && load_ready;

   // frame state and per-request burst descriptor
   nfcfb_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .frame_length  (req_frame_length),
      .write_command (write_command_ff),
      .burst         (burst)
   );

   // steps through the burst and drives the result channel
   nfcfb_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .burst_next    (burst),
      .load_ready    (load_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
